// ----- rtl/slm_pkg.sv -----
`timescale 1ns / 1ps

package slm_pkg;

    // List capacity and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOT_W   = $clog2(2 * DEPTH + 1);
    localparam int VAL_W   = 32;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Input kind codes
    localparam logic [1:0] KIND_APPEND_A = 2'd0;
    localparam logic [1:0] KIND_APPEND_B = 2'd1;
    localparam logic [1:0] KIND_MERGE    = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPEND_A,
        CMD_APPEND_B,
        CMD_MERGE
    } slm_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } slm_state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
    } slm_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic                    from_b;
        logic                    last;
        logic                    overflow;
    } slm_out_t;

    typedef struct packed {
        slm_cmd_t                cmd;
        logic signed [VAL_W-1:0] value;
    } slm_qword_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        slm_qword_t word;
    } slm_qhead_t;

endpackage

// ----- rtl/slm_front.sv -----
`timescale 1ns / 1ps

module slm_front
    import slm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  slm_in_t    item,
    input  logic       pop,
    output slm_qhead_t head
);

    slm_qword_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               kind_ok;
    logic               push;
    logic               do_pop;
    slm_qword_t         word_in;

    // Classify the incoming word; drop unused kinds here
    always_comb
    begin
        kind_ok       = 1'b1;
        word_in.value = item.value;
        word_in.cmd   = CMD_APPEND_A;
        unique case (item.kind)
            KIND_APPEND_A: word_in.cmd = CMD_APPEND_A;
            KIND_APPEND_B: word_in.cmd = CMD_APPEND_B;
            KIND_MERGE:    word_in.cmd = CMD_MERGE;
            default:       kind_ok     = 1'b0;
        endcase
    end

    assign busy   = (cnt_reg == QCNT_W'(QDEPTH));
    assign push   = start && !busy && kind_ok;
    assign do_pop = pop && (cnt_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= word_in;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.word  = q_reg[rd_ptr_reg];

endmodule

// ----- rtl/slm_back.sv -----
`timescale 1ns / 1ps

module slm_back
    import slm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slm_qhead_t head,
    output logic       pop,
    output logic       result_valid,
    output slm_out_t   result
);

    logic signed [VAL_W-1:0] list_a_mem [DEPTH];
    logic signed [VAL_W-1:0] list_b_mem [DEPTH];

    slm_state_t         state_reg;
    slm_state_t         state_next;
    logic [CNT_W-1:0]   count_a_reg;
    logic [CNT_W-1:0]   count_a_next;
    logic [CNT_W-1:0]   count_b_reg;
    logic [CNT_W-1:0]   count_b_next;
    logic [CNT_W-1:0]   ia_reg;
    logic [CNT_W-1:0]   ia_next;
    logic [CNT_W-1:0]   ib_reg;
    logic [CNT_W-1:0]   ib_next;
    logic [TOT_W-1:0]   rem_reg;
    logic [TOT_W-1:0]   rem_next;
    logic               drop_reg;
    logic               drop_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    slm_out_t           res_reg;
    slm_out_t           res_next;

    logic [TOT_W-1:0]        total;
    logic                    start_merge;
    logic                    emit;
    logic                    wr_a;
    logic                    wr_b;
    logic                    a_ok;
    logic                    b_ok;
    logic                    take_a;
    logic signed [VAL_W-1:0] a_head;
    logic signed [VAL_W-1:0] b_head;

    assign total  = TOT_W'(count_a_reg) + TOT_W'(count_b_reg);
    assign a_head = list_a_mem[ia_reg[IDX_W-1:0]];
    assign b_head = list_b_mem[ib_reg[IDX_W-1:0]];
    assign a_ok   = (ia_reg < count_a_reg);
    assign b_ok   = (ib_reg < count_b_reg);
    // On equal heads B goes first
    assign take_a = a_ok && (!b_ok || (a_head < b_head));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.word.cmd == CMD_MERGE && total != '0)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (rem_reg == TOT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        pop         = 1'b0;
        emit        = 1'b0;
        start_merge = 1'b0;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = head.valid;
                if (head.valid)
                begin
                    unique case (head.word.cmd)
                        CMD_APPEND_A: wr_a        = (count_a_reg < CNT_W'(DEPTH));
                        CMD_APPEND_B: wr_b        = (count_b_reg < CNT_W'(DEPTH));
                        CMD_MERGE:    start_merge = 1'b1;
                        default:      start_merge = 1'b0;
                    endcase
                end
            end
            ST_MERGE: emit = 1'b1;
            default:  emit = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        rem_next       = rem_reg;
        drop_next      = drop_reg;
        ovf_next       = ovf_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        // Append, or mark the drop on a full list
        if (wr_a)
        begin
            count_a_next = count_a_reg + 1'b1;
        end
        if (wr_b)
        begin
            count_b_next = count_b_reg + 1'b1;
        end
        if (pop && !start_merge && !wr_a && !wr_b)
        begin
            drop_next = 1'b1;
        end

        // Latch run length and flag at the merge start
        if (start_merge)
        begin
            ia_next  = '0;
            ib_next  = '0;
            rem_next = total;
            ovf_next = drop_reg;
            if (total == '0)
            begin
                drop_next = 1'b0;
            end
        end

        // Emit one element per cycle
        if (emit)
        begin
            res_valid_next        = 1'b1;
            res_next.merged_value = take_a ? a_head : b_head;
            res_next.from_b       = !take_a;
            res_next.last         = (rem_reg == TOT_W'(1));
            res_next.overflow     = ovf_reg;
            rem_next              = rem_reg - 1'b1;
            if (take_a)
            begin
                ia_next = ia_reg + 1'b1;
            end
            else
            begin
                ib_next = ib_reg + 1'b1;
            end
            if (rem_reg == TOT_W'(1))
            begin
                count_a_next = '0;
                count_b_next = '0;
                drop_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            rem_reg       <= '0;
            drop_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            ia_reg        <= ia_next;
            ib_reg        <= ib_next;
            rem_reg       <= rem_next;
            drop_reg      <= drop_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload and list storage
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_a)
        begin
            list_a_mem[count_a_reg[IDX_W-1:0]] <= head.word.value;
        end
        if (wr_b)
        begin
            list_b_mem[count_b_reg[IDX_W-1:0]] <= head.word.value;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/sorted_list_merge_unit.sv -----
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     start & !busy         item   (kind, value)
// result    result_valid strobe   result (merged_value, from_b, last, overflow)
//
// Accepted words of a known kind enter a two-word command queue; busy is high while it
// is full. The back end takes one queued word per cycle when idle. A merge then gives
// one result per cycle, count_a + count_b in all; results leave a register in the cycle
// after they are picked. Reset empties both lists, the queue and the overflow flag;
// results cannot be stalled.

module sorted_list_merge_unit
    import slm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  slm_in_t  item,
    output logic     result_valid,
    output slm_out_t result
);

    slm_qhead_t head;
    logic       pop;

    slm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    slm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- verif/slm_merge_checker.sv -----
`timescale 1ns / 1ps

module slm_merge_checker
    import slm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  slm_in_t  item,
    input  logic     result_valid,
    input  slm_out_t result,
    output int       fail_count,
    output int       outstanding
);

    // Shadow copy of both lists and the sticky drop flag
    logic signed [VAL_W-1:0] list_a [DEPTH];
    logic signed [VAL_W-1:0] list_b [DEPTH];
    int                      len_a;
    int                      len_b;
    logic                    dropped;

    // Merge words predicted but not yet seen on the result port
    slm_out_t                merge_words_due [$];
    int                      errors = 0;

    // Fold one accepted word into the lists; a merge queues its whole run
    task automatic absorb_word(input slm_in_t w);
        int       ia;
        int       ib;
        bit       take_a;
        slm_out_t r;
        ia = 0;
        ib = 0;
        case (w.kind)
            KIND_APPEND_A:
            begin
                if (len_a < DEPTH)
                begin
                    list_a[len_a] = w.value;
                    len_a++;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
            KIND_APPEND_B:
            begin
                if (len_b < DEPTH)
                begin
                    list_b[len_b] = w.value;
                    len_b++;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
            KIND_MERGE:
            begin
                // take A only when strictly smaller; equal heads go to B
                while (ia + ib < len_a + len_b)
                begin
                    take_a = (ia < len_a) && ((ib >= len_b) || (list_a[ia] < list_b[ib]));
                    if (take_a)
                    begin
                        r.merged_value = list_a[ia];
                        r.from_b       = 1'b0;
                        ia++;
                    end
                    else
                    begin
                        r.merged_value = list_b[ib];
                        r.from_b       = 1'b1;
                        ib++;
                    end
                    r.last     = (ia + ib == len_a + len_b);
                    r.overflow = dropped;
                    merge_words_due.push_back(r);
                end
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
            end
            default:
            begin
                // unused kind: no effect
            end
        endcase
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_result(input slm_out_t got);
        slm_out_t want;
        if (merge_words_due.size() == 0)
        begin
            $error("unexpected result word: merged_value %0d from_b %0b last %0b overflow %0b",
                   got.merged_value, got.from_b, got.last, got.overflow);
            errors++;
        end
        else
        begin
            want = merge_words_due.pop_front();
            if (got.merged_value !== want.merged_value)
            begin
                $error("merged_value: expected %0d, got %0d", want.merged_value,
                       got.merged_value);
                errors++;
            end
            if (got.from_b !== want.from_b)
            begin
                $error("from_b: expected %0b, got %0b", want.from_b, got.from_b);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                errors++;
            end
        end
    endtask

    // Watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a   = 0;
            len_b   = 0;
            dropped = 1'b0;
            merge_words_due.delete();
            outstanding <= 0;
            fail_count  <= errors;
        end
        else
        begin
            if (result_valid)
            begin
                check_result(result);
            end
            if (start && !busy)
            begin
                absorb_word(item);
            end
            outstanding <= merge_words_due.size();
            fail_count  <= errors;
        end
    end

endmodule

// ----- verif/sorted_list_merge_unit_tb.sv -----
`timescale 1ns / 1ps

module sorted_list_merge_unit_tb;
    import slm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 430;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    slm_in_t  item;
    logic     result_valid;
    slm_out_t result;
    int       fail_count;
    int       outstanding;

    int       items_sent   = 0;
    int       burst_left   = 0;
    int       quiet_cycles = 0;

    // Ascending runs waiting to be appended
    logic signed [VAL_W-1:0] run_a [$];
    logic signed [VAL_W-1:0] run_b [$];

    sorted_list_merge_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    slm_merge_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #2 clk = ~clk;

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and hold it until taken; idle between bursts
    task automatic send_word(input logic [1:0] word_kind, input logic signed [VAL_W-1:0] word_value);
        int gap;
        start <= 1'b1;
        item  <= '{kind: word_kind, value: word_value};
        do
        begin
            @(posedge clk);
        end
        while (busy);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                item  <= '{kind: 2'($urandom), value: $urandom};
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
    endtask

    // Hold off until every predicted merge word has come out
    task automatic wait_for_drain();
        if (start)
        begin
            start <= 1'b0;
        end
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // Advance a run value; zero steps give repeats, clamp at the top
    function automatic logic signed [VAL_W-1:0] step_up(input logic signed [VAL_W-1:0] v);
        longint next_v;
        case ($urandom_range(0, 3))
            0:       next_v = v;
            1:       next_v = longint'(v) + longint'($urandom_range(1, 16));
            2:       next_v = longint'(v) + longint'($urandom_range(1, 1 << 20));
            default: next_v = longint'(v) + longint'($urandom >> $urandom_range(1, 8));
        endcase
        if (next_v > longint'(VAL_MAX))
        begin
            next_v = longint'(VAL_MAX);
        end
        return next_v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] run_origin();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX - $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    // Mostly short lists, some up to full length, a few that spill over
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
        begin
            return $urandom_range(0, 8);
        end
        else if (r < 19)
        begin
            return $urandom_range(0, DEPTH);
        end
        return $urandom_range(DEPTH + 1, DEPTH + 3);
    endfunction

    // Append two ascending runs interleaved, then merge them
    task automatic play_round(input int na, input int nb);
        logic signed [VAL_W-1:0] va;
        logic signed [VAL_W-1:0] vb;
        run_a.delete();
        run_b.delete();
        va = run_origin();
        vb = ($urandom_range(0, 1) == 0) ? va : run_origin();
        for (int i = 0; i < na; i++)
        begin
            run_a.push_back(va);
            va = step_up(va);
        end
        for (int i = 0; i < nb; i++)
        begin
            run_b.push_back(vb);
            vb = step_up(vb);
        end
        // mix in unused kinds and out-of-order values now and then
        while (run_a.size() + run_b.size() > 0)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_word(KIND_UNUSED, $urandom);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                send_word(($urandom_range(0, 1) == 0) ? KIND_APPEND_A : KIND_APPEND_B, $urandom);
            end
            else if (run_b.size() == 0 || (run_a.size() > 0 && $urandom_range(0, 1) == 0))
            begin
                send_word(KIND_APPEND_A, run_a.pop_front());
            end
            else
            begin
                send_word(KIND_APPEND_B, run_b.pop_front());
            end
        end
        send_word(KIND_MERGE, $urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            send_word(KIND_MERGE, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // merge of two empty lists
        send_word(KIND_MERGE, 32'sd0);
        // extremes, equal heads, unused kind
        send_word(KIND_APPEND_A, VAL_MIN);
        send_word(KIND_APPEND_B, VAL_MIN);
        send_word(KIND_APPEND_A, -32'sd1);
        send_word(KIND_APPEND_B, 32'sd0);
        send_word(KIND_APPEND_A, VAL_MAX);
        send_word(KIND_APPEND_B, VAL_MAX);
        send_word(KIND_UNUSED, 32'sh5a5a_a5a5);
        send_word(KIND_MERGE, VAL_MAX);
        // one side empty
        send_word(KIND_APPEND_A, 32'sh1234_5678);
        send_word(KIND_MERGE, -32'sd1);
        send_word(KIND_APPEND_B, -32'sd7);
        send_word(KIND_MERGE, 32'sd0);
        wait_for_drain();

        // overfilled list on each side, then random rounds
        play_round(DEPTH + 2, 3);
        play_round(2, DEPTH + 1);
        while (items_sent < ITEM_TARGET)
        begin
            play_round(pick_length(), pick_length());
            if ($urandom_range(0, 5) == 0)
            begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
